>>> hw/rtl/pdgs_pkg.sv
// ----------------------------------------------------------------------------
// pdgs_pkg
// Shared widths, register indexes and reset values for the gimbal servo
// pulse block.
// ----------------------------------------------------------------------------
package pdgs_pkg;

    // payload widths
    localparam int ErrW      = 16;
    localparam int PulseW    = 12;
    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 20;

    // register field widths
    localparam int PropW  = 16;
    localparam int DerivW = 20;
    localparam int LimW   = 12;
    localparam int PpdW   = 16;

    // fraction bits of the command (Q.21) and of the pulse (Q.29)
    localparam int CmdFracW   = 21;
    localparam int PulseFracW = 29;
    localparam int ErrFracW   = 13;

    // configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_DERIV_GAIN     = 3'd1,
        REG_DEFLECT_LIMIT  = 3'd2,
        REG_PULSE_PER_DEG  = 3'd3,
        REG_TRIM_PULSE     = 3'd4,
        REG_PULSE_FLOOR    = 3'd5,
        REG_PULSE_CEILING  = 3'd6,
        REG_INVERT_DIR     = 3'd7
    } cfg_index_t;

    // register reset values
    localparam logic [PropW-1:0]  PropGainRst   = 16'd5888;
    localparam logic [DerivW-1:0] DerivGainRst  = 20'd384000;
    localparam logic [LimW-1:0]   DeflectRst    = 12'd1536;
    localparam logic [PpdW-1:0]   PulsePerDegRst = 16'd11366;
    localparam logic [PulseW-1:0] TrimRst       = 12'd1575;
    localparam logic [PulseW-1:0] FloorRst      = 12'd1200;
    localparam logic [PulseW-1:0] CeilingRst    = 12'd1900;

endpackage

>>> hw/rtl/pdgs_if.sv
// ----------------------------------------------------------------------------
// pdgs channel interfaces
// Valid/ready channels for error samples, pulse results and register writes.
// ----------------------------------------------------------------------------

// error sample channel
interface pdgs_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [pdgs_pkg::ErrW-1:0]    attitude_error;

    modport source (output valid, output attitude_error, input ready);
    modport sink   (input valid, input attitude_error, output ready);
endinterface

// pulse result channel
interface pdgs_out_if;
    logic                                valid;
    logic                                ready;
    logic [pdgs_pkg::PulseW-1:0]         pulse_width;
    logic                                command_limited;
    logic                                pulse_limited;

    modport source (output valid, output pulse_width, output command_limited,
                    output pulse_limited, input ready);
    modport sink   (input valid, input pulse_width, input command_limited,
                    input pulse_limited, output ready);
endinterface

// register write channel
interface pdgs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pdgs_pkg::CfgIndexW-1:0]      index;
    logic [pdgs_pkg::CfgDataW-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/pd_gimbal_servo_pulse.sv
// ----------------------------------------------------------------------------
// pd_gimbal_servo_pulse
// One-axis PD gimbal controller with command and pulse-width clamps.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one signed Q2.13 attitude error per control tick (valid/ready).
//   result : one item per sample: pulse width in whole microseconds plus
//            flags telling whether the command or the pulse was clipped.
//   cfg    : register writes, index 0..7, always ready; write only while
//            the block is idle.
// Timing:
//   After a sample is accepted, the sequencer steps one shared 21x26 signed
//   multiplier through the proportional, derivative and pulse-scale
//   products, with one adder and comparator pass for the sum, the command
//   clamp, the trim offset and the pulse clamp, and then writes the result
//   register. One sample is in work at a time. The next sample is taken
//   while a finished result still waits.
// Reset:
//   Registers return to their default tuning and the stored previous error
//   is zero. No item is pending.
// Stall:
//   If the receiver holds ready low, the finished result stays in the output
//   register and the sequencer holds in its last step, taking no sample,
//   until the output register has room for the next one.
// ----------------------------------------------------------------------------
module pd_gimbal_servo_pulse (
    input  logic               clk,
    input  logic               rst_n,
    pdgs_in_if.sink            sample,
    pdgs_out_if.source         result,
    pdgs_cfg_if.sink           cfg
);
    import pdgs_pkg::*;

    localparam int MulAW = 21;
    localparam int MulBW = 26;
    localparam int ProdW = MulAW + MulBW;
    localparam int AccW  = 45;
    localparam int CmdW  = 26;
    localparam int DiffW = ErrW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_D,
        S_SUM,
        S_CLAMP_CMD,
        S_MUL_O,
        S_OFFSET,
        S_CLAMP_PULSE
    } state_t;

    // configuration registers
    logic [PropW-1:0]   prop_gain_reg;
    logic [DerivW-1:0]  deriv_gain_reg;
    logic [LimW-1:0]    deflect_limit_reg;
    logic [PpdW-1:0]    pulse_per_deg_reg;
    logic [PulseW-1:0]  trim_reg;
    logic [PulseW-1:0]  floor_reg;
    logic [PulseW-1:0]  ceiling_reg;
    logic               invert_reg;

    // sequencer and datapath state
    state_t                   state_reg;
    logic signed [ErrW-1:0]   err_reg;
    logic signed [ErrW-1:0]   prev_reg;
    logic signed [DiffW-1:0]  diff_reg;
    logic signed [ProdW-1:0]  prod_reg;
    logic signed [AccW-1:0]   acc_reg;
    logic signed [CmdW-1:0]   cmd_reg;
    logic                     cmd_lim_reg;

    // output register
    logic                     out_valid_reg;
    logic [PulseW-1:0]        out_width_reg;
    logic                     out_cmd_lim_reg;
    logic                     out_pls_lim_reg;

    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic signed [ProdW-1:0]  mul_p;
    logic signed [AccW-1:0]   lim_pos;
    logic signed [AccW-1:0]   lim_neg;
    logic signed [AccW-1:0]   trim_q29;
    logic signed [AccW-1:0]   floor_q29;
    logic signed [AccW-1:0]   ceil_q29;
    logic signed [AccW-1:0]   offs;
    logic                     sample_take;
    logic                     out_free;

    assign sample.ready = (state_reg == S_IDLE);
    assign sample_take  = sample.valid && sample.ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign cfg.ready    = 1'b1;

    assign result.valid           = out_valid_reg;
    assign result.pulse_width     = out_width_reg;
    assign result.command_limited = out_cmd_lim_reg;
    assign result.pulse_limited   = out_pls_lim_reg;

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_MUL_P:
            begin
                mul_a = $signed({{(MulAW-PropW){1'b0}}, prop_gain_reg});
                mul_b = MulBW'(err_reg);
            end
            S_MUL_D:
            begin
                mul_a = $signed({{(MulAW-DerivW){1'b0}}, deriv_gain_reg});
                mul_b = MulBW'(diff_reg);
            end
            default:
            begin
                mul_a = $signed({{(MulAW-PpdW){1'b0}}, pulse_per_deg_reg});
                mul_b = cmd_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // limits and offsets scaled to the accumulator format
    assign lim_pos   = $signed({{(AccW-LimW-ErrFracW){1'b0}}, deflect_limit_reg,
                                {ErrFracW{1'b0}}});
    assign lim_neg   = -lim_pos;
    assign trim_q29  = $signed({{(AccW-PulseW-PulseFracW){1'b0}}, trim_reg,
                                {PulseFracW{1'b0}}});
    assign floor_q29 = $signed({{(AccW-PulseW-PulseFracW){1'b0}}, floor_reg,
                                {PulseFracW{1'b0}}});
    assign ceil_q29  = $signed({{(AccW-PulseW-PulseFracW){1'b0}}, ceiling_reg,
                                {PulseFracW{1'b0}}});
    assign offs      = invert_reg ? -prod_reg[AccW-1:0] : prod_reg[AccW-1:0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= PropGainRst;
            deriv_gain_reg    <= DerivGainRst;
            deflect_limit_reg <= DeflectRst;
            pulse_per_deg_reg <= PulsePerDegRst;
            trim_reg          <= TrimRst;
            floor_reg         <= FloorRst;
            ceiling_reg       <= CeilingRst;
            invert_reg        <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                REG_PROP_GAIN:     prop_gain_reg     <= cfg.data[PropW-1:0];
                REG_DERIV_GAIN:    deriv_gain_reg    <= cfg.data[DerivW-1:0];
                REG_DEFLECT_LIMIT: deflect_limit_reg <= cfg.data[LimW-1:0];
                REG_PULSE_PER_DEG: pulse_per_deg_reg <= cfg.data[PpdW-1:0];
                REG_TRIM_PULSE:    trim_reg          <= cfg.data[PulseW-1:0];
                REG_PULSE_FLOOR:   floor_reg         <= cfg.data[PulseW-1:0];
                REG_PULSE_CEILING: ceiling_reg       <= cfg.data[PulseW-1:0];
                REG_INVERT_DIR:    invert_reg        <= cfg.data[0];
                default:           invert_reg        <= invert_reg;
            endcase
        end
    end

    // sequencer, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            prev_reg        <= '0;
            out_valid_reg   <= 1'b0;
            err_reg         <= '0;
            diff_reg        <= '0;
            prod_reg        <= '0;
            acc_reg         <= '0;
            cmd_reg         <= '0;
            cmd_lim_reg     <= 1'b0;
            out_width_reg   <= '0;
            out_cmd_lim_reg <= 1'b0;
            out_pls_lim_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                // take a sample, form the error difference
                S_IDLE:
                begin
                    if (sample_take)
                    begin
                        err_reg   <= sample.attitude_error;
                        prev_reg  <= sample.attitude_error;
                        diff_reg  <= DiffW'(sample.attitude_error) - DiffW'(prev_reg);
                        state_reg <= S_MUL_P;
                    end
                end
                // proportional product
                S_MUL_P:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MUL_D;
                end
                // derivative product
                S_MUL_D:
                begin
                    acc_reg   <= prod_reg[AccW-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= S_SUM;
                end
                // PD sum
                S_SUM:
                begin
                    acc_reg   <= acc_reg + prod_reg[AccW-1:0];
                    state_reg <= S_CLAMP_CMD;
                end
                // clamp command to the deflection limit
                S_CLAMP_CMD:
                begin
                    if (acc_reg > lim_pos)
                    begin
                        cmd_reg     <= lim_pos[CmdW-1:0];
                        cmd_lim_reg <= 1'b1;
                    end
                    else if (acc_reg < lim_neg)
                    begin
                        cmd_reg     <= lim_neg[CmdW-1:0];
                        cmd_lim_reg <= 1'b1;
                    end
                    else
                    begin
                        cmd_reg     <= acc_reg[CmdW-1:0];
                        cmd_lim_reg <= 1'b0;
                    end
                    state_reg <= S_MUL_O;
                end
                // scale command to microseconds
                S_MUL_O:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_OFFSET;
                end
                // add trim with direction sign
                S_OFFSET:
                begin
                    acc_reg   <= trim_q29 + offs;
                    state_reg <= S_CLAMP_PULSE;
                end
                // floor first, then ceiling, then drop fraction bits;
                // hold here until the output register has room
                S_CLAMP_PULSE:
                begin
                    if (out_free)
                    begin
                        out_cmd_lim_reg <= cmd_lim_reg;
                        if (acc_reg < floor_q29)
                        begin
                            out_width_reg   <= floor_reg;
                            out_pls_lim_reg <= 1'b1;
                        end
                        else if (acc_reg > ceil_q29)
                        begin
                            out_width_reg   <= ceiling_reg;
                            out_pls_lim_reg <= 1'b1;
                        end
                        else
                        begin
                            out_width_reg   <= acc_reg[PulseFracW+PulseW-1:PulseFracW];
                            out_pls_lim_reg <= 1'b0;
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> verif/pdgs_pulse_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pdgs_pulse_check
// Watches the sample, result and register channels of the gimbal servo pulse
// block. Keeps its own copy of the tuning registers and the previous error,
// predicts the pulse item for every accepted sample and compares each
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module pdgs_pulse_check (
    input  logic clk,
    input  logic rst_n,
    pdgs_in_if   sample,
    pdgs_out_if  result,
    pdgs_cfg_if  cfg,
    output int   fail_count,
    output int   pending
);
    import pdgs_pkg::*;

    // fraction bits of the deflection limit register (Q4.8)
    localparam int LimFracW = 8;

    typedef struct packed {
        logic [PulseW-1:0] pulse_width;
        logic              command_limited;
        logic              pulse_limited;
    } pulse_item_t;

    // tuning registers as the block should hold them
    logic [PropW-1:0]         prop_gain;
    logic [DerivW-1:0]        deriv_gain;
    logic [LimW-1:0]          deflect_limit;
    logic [PpdW-1:0]          pulse_per_degree;
    logic [PulseW-1:0]        trim_pulse;
    logic [PulseW-1:0]        pulse_floor;
    logic [PulseW-1:0]        pulse_ceiling;
    logic                     invert_direction;
    logic signed [ErrW-1:0]   last_error;

    pulse_item_t pulse_q[$];
    pulse_item_t want;

    // pd command, deflection clamp, pulse mapping and stop clamp
    function automatic pulse_item_t predict_pulse(input logic signed [ErrW-1:0] err);
        longint      diff;
        longint      cmd;
        longint      lim;
        longint      offs;
        longint      pulse;
        longint      lo;
        longint      hi;
        pulse_item_t r;
        r    = '0;
        diff = longint'(err) - longint'(last_error);
        cmd  = longint'(prop_gain) * longint'(err) + longint'(deriv_gain) * diff;
        lim  = longint'(deflect_limit) <<< (CmdFracW - LimFracW);
        if (cmd > lim)
        begin
            cmd               = lim;
            r.command_limited = 1'b1;
        end
        else if (cmd < -lim)
        begin
            cmd               = -lim;
            r.command_limited = 1'b1;
        end
        offs = cmd * longint'(pulse_per_degree);
        if (invert_direction)
            offs = -offs;
        pulse = (longint'(trim_pulse) <<< PulseFracW) + offs;
        lo    = longint'(pulse_floor) <<< PulseFracW;
        hi    = longint'(pulse_ceiling) <<< PulseFracW;
        // floor is tested first, so floor above ceiling gives the floor
        if (pulse < lo)
        begin
            pulse           = lo;
            r.pulse_limited = 1'b1;
        end
        else if (pulse > hi)
        begin
            pulse           = hi;
            r.pulse_limited = 1'b1;
        end
        r.pulse_width = pulse[PulseFracW +: PulseW];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain        = PropGainRst;
            deriv_gain       = DerivGainRst;
            deflect_limit    = DeflectRst;
            pulse_per_degree = PulsePerDegRst;
            trim_pulse       = TrimRst;
            pulse_floor      = FloorRst;
            pulse_ceiling    = CeilingRst;
            invert_direction = 1'b0;
            last_error       = '0;
            pulse_q.delete();
            pending          = 0;
        end
        else
        begin
            // register writes
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_index_t'(cfg.index))
                    REG_PROP_GAIN:     prop_gain        = cfg.data[PropW-1:0];
                    REG_DERIV_GAIN:    deriv_gain       = cfg.data[DerivW-1:0];
                    REG_DEFLECT_LIMIT: deflect_limit    = cfg.data[LimW-1:0];
                    REG_PULSE_PER_DEG: pulse_per_degree = cfg.data[PpdW-1:0];
                    REG_TRIM_PULSE:    trim_pulse       = cfg.data[PulseW-1:0];
                    REG_PULSE_FLOOR:   pulse_floor      = cfg.data[PulseW-1:0];
                    REG_PULSE_CEILING: pulse_ceiling    = cfg.data[PulseW-1:0];
                    REG_INVERT_DIR:    invert_direction = cfg.data[0];
                    default: ;
                endcase
            end

            // compare a finished pulse item with the oldest prediction
            if (result.valid && result.ready)
            begin
                if (pulse_q.size() == 0)
                begin
                    $error("unexpected pulse item: pulse_width %0d", result.pulse_width);
                    fail_count++;
                end
                else
                begin
                    want = pulse_q.pop_front();
                    if (result.pulse_width !== want.pulse_width)
                    begin
                        $error("pulse_width: expected %0d, got %0d",
                               want.pulse_width, result.pulse_width);
                        fail_count++;
                    end
                    if (result.command_limited !== want.command_limited)
                    begin
                        $error("command_limited: expected %0b, got %0b",
                               want.command_limited, result.command_limited);
                        fail_count++;
                    end
                    if (result.pulse_limited !== want.pulse_limited)
                    begin
                        $error("pulse_limited: expected %0b, got %0b",
                               want.pulse_limited, result.pulse_limited);
                        fail_count++;
                    end
                end
            end

            // predict the item for an accepted error sample
            if (sample.valid && sample.ready)
            begin
                pulse_q.push_back(predict_pulse(sample.attitude_error));
                last_error = sample.attitude_error;
            end

            pending = pulse_q.size();
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives error samples and register writes into the gimbal servo pulse block
// under random sender gaps and receiver stalls. A directed opening covers the
// error extremes and the clamp boundaries; random phases follow with default,
// all-ones, all-zero and random tunings. The checker beside the block does
// the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import pdgs_pkg::*;

    localparam int CycleLimit   = 1_000_000;
    localparam int RandomPhases = 12;
    localparam int PhaseItems   = 150;
    localparam int MaxGap       = 19;
    localparam int SettleCycles = 12;
    localparam int ResetCycles  = 12;
    localparam int PulseMax     = (1 << PulseW) - 1;

    logic                   clk;
    logic                   rst_n;
    bit                     quiet;
    int                     cycle_count = 0;
    int                     fail_count;
    int                     pending;
    logic signed [ErrW-1:0] last_sent;

    pdgs_in_if  sample_ch ();
    pdgs_out_if result_ch ();
    pdgs_cfg_if cfg_ch ();

    pd_gimbal_servo_pulse dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    pdgs_pulse_check pulse_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("pd_gimbal_servo_pulse verification failed");
            $finish;
        end
    end

    // receiver: random stall before taking each pulse item
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, MaxGap);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
        end
    end

    // one error sample, after a random gap
    task automatic send_error(input logic signed [ErrW-1:0] err);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MaxGap);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.attitude_error <= err;
        do
            @(posedge clk);
        while (!(sample_ch.valid && sample_ch.ready));
        last_sent = err;
    endtask

    // hold off samples until every predicted item has come out
    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // leaves valid high so back-to-back writes need no drop in between
    task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
    endtask

    // full tuning, written only once the block is idle
    task automatic apply_tuning(input logic [PropW-1:0]  prop,
                                input logic [DerivW-1:0] deriv,
                                input logic [LimW-1:0]   limit,
                                input logic [PpdW-1:0]   ppd,
                                input logic [PulseW-1:0] trim,
                                input logic [PulseW-1:0] floor_us,
                                input logic [PulseW-1:0] ceiling_us,
                                input logic              invert);
        wait_for_results();
        write_reg(REG_PROP_GAIN, CfgDataW'(prop));
        write_reg(REG_DERIV_GAIN, CfgDataW'(deriv));
        write_reg(REG_DEFLECT_LIMIT, CfgDataW'(limit));
        write_reg(REG_PULSE_PER_DEG, CfgDataW'(ppd));
        write_reg(REG_TRIM_PULSE, CfgDataW'(trim));
        write_reg(REG_PULSE_FLOOR, CfgDataW'(floor_us));
        write_reg(REG_PULSE_CEILING, CfgDataW'(ceiling_us));
        write_reg(REG_INVERT_DIR, CfgDataW'(invert));
        cfg_ch.valid <= 1'b0;
    endtask

    // gains spread over many magnitudes, stops mostly around the trim
    task automatic apply_random_tuning();
        logic [PulseW-1:0] trim;
        int                span;
        int                lo_v;
        int                hi_v;
        trim = PulseW'($urandom);
        span = $urandom_range(0, 1500);
        if ($urandom_range(0, 3) == 0)
        begin
            lo_v = $urandom_range(0, PulseMax);
            hi_v = $urandom_range(0, PulseMax);
        end
        else
        begin
            lo_v = int'(trim) - span;
            hi_v = int'(trim) + span;
        end
        if (lo_v < 0)
            lo_v = 0;
        if (hi_v > PulseMax)
            hi_v = PulseMax;
        apply_tuning(PropW'($urandom) >> $urandom_range(0, PropW - 1),
                     DerivW'($urandom) >> $urandom_range(0, DerivW - 1),
                     LimW'($urandom),
                     PpdW'($urandom) >> $urandom_range(0, PpdW - 1),
                     trim, PulseW'(lo_v), PulseW'(hi_v),
                     1'($urandom_range(0, 1)));
    endtask

    // full range, scaled down, small steps from the last sample, or extremes
    function automatic logic signed [ErrW-1:0] random_error(
        input logic signed [ErrW-1:0] prev);
        logic signed [ErrW-1:0] err;
        case ($urandom_range(0, 3))
            0: err = ErrW'($urandom);
            1: err = $signed(ErrW'($urandom)) >>> $urandom_range(3, ErrW - 2);
            2: err = prev + $signed(8'($urandom));
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       err = 16'sh7FFF;
                    1:       err = 16'sh8000;
                    2:       err = '0;
                    default: err = -16'sd1;
                endcase
            end
        endcase
        return err;
    endfunction

    // reset, directed cases, random phases, verdict
    initial
    begin
        rst_n                    <= 1'b0;
        sample_ch.valid          <= 1'b0;
        sample_ch.attitude_error <= '0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.index             <= REG_PROP_GAIN;
        cfg_ch.data              <= '0;
        quiet     = 1'b0;
        last_sent = '0;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset tuning: error extremes and the largest derivative steps
        send_error(16'sd0);
        send_error(16'sd1);
        send_error(-16'sd1);
        send_error(16'sh7FFF);
        send_error(16'sh8000);
        send_error(16'sh7FFF);
        send_error(16'sd0);
        send_error(16'sd100);

        // command exactly at the deflection limit and one step past it
        apply_tuning(16'd256, 20'd0, 12'd1000, 16'd256, 12'd2048, 12'd0,
                     12'd4095, 1'b0);
        send_error(16'sd32000);
        send_error(16'sd32001);
        send_error(-16'sd32000);
        send_error(-16'sd32001);

        // pulse exactly at ceiling and floor and one step past each
        apply_tuning(16'd256, 20'd0, 12'd4095, 16'd2560, 12'd1500, 12'd1490,
                     12'd1510, 1'b0);
        send_error(16'sd8192);
        send_error(16'sd8193);
        send_error(-16'sd8192);
        send_error(-16'sd8193);
        send_error(16'sd4096);

        // zero deflection limit: limited only when the command is nonzero
        apply_tuning(PropGainRst, DerivGainRst, 12'd0, PulsePerDegRst, TrimRst,
                     FloorRst, CeilingRst, 1'b0);
        send_error(16'sd0);
        send_error(16'sd0);
        send_error(16'sd7);

        // floor above ceiling
        apply_tuning(PropGainRst, DerivGainRst, DeflectRst, PulsePerDegRst, TrimRst,
                     12'd2000, 12'd1000, 1'b0);
        send_error(16'sd0);
        send_error(16'sh7FFF);

        // random phases, each under its own tuning
        for (int p = 0; p < RandomPhases; p++)
        begin
            case (p)
                0: apply_tuning(PropGainRst, DerivGainRst, DeflectRst, PulsePerDegRst,
                                TrimRst, FloorRst, CeilingRst, 1'b0);
                1: apply_tuning({PropW{1'b1}}, {DerivW{1'b1}}, {LimW{1'b1}},
                                {PpdW{1'b1}}, {PulseW{1'b1}}, {PulseW{1'b1}},
                                {PulseW{1'b1}}, 1'b1);
                2: apply_tuning('0, '0, '0, '0, '0, '0, '0, 1'b0);
                default: apply_random_tuning();
            endcase
            for (int i = 0; i < PhaseItems; i++)
            begin
                if (i % 40 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) == 0)
                    wait_for_results();
                send_error(random_error(last_sent));
            end
        end

        wait_for_results();
        if (fail_count == 0)
            $display("pd_gimbal_servo_pulse verification clean");
        else
            $display("pd_gimbal_servo_pulse verification failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pdgs_pkg.sv
hw/rtl/pdgs_if.sv
hw/rtl/pd_gimbal_servo_pulse.sv
verif/pdgs_pulse_check.sv
verif/testbench.sv
